### src/apt_pkg.sv
// shared types and constants for the affine point transform
`default_nettype none

package apt_pkg;

    localparam int COORD_W      = 32;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int PAIR_W       = 2 * COORD_W;
    localparam int NUM_REGS     = 6;
    localparam int NUM_ENTRIES  = 2 * NUM_REGS;
    localparam int CFG_IDX_W    = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PIPE_DEPTH   = 4;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_coef;
    typedef t_coef [NUM_ENTRIES-1:0] t_matrix;

endpackage

`default_nettype wire

### src/affine_point_transform_top.sv
// affine point transform top level: config registers, three coordinate lanes
//
// usage
//   input: a point (i_point_x/y/z, signed fixed point) transfers on a rising
//   edge with start high and busy low; busy is never raised, so one point
//   can transfer every clock
//   output: o_strobe is high for exactly one cycle with o_out_x/y/z and
//   o_saturated; the receiver takes the result in that cycle and cannot stall
//   pipeline: from the input transfer to the strobe cycle a point passes
//   the multiply, two adder levels and shift and saturate, one register each
//   throughput: one point per clock, set by the fully pipelined lanes
//   config: write i_cfg_data to register i_cfg_index when i_cfg_valid and
//   o_cfg_ready are high; indexes above five are dropped; write only while
//   no point is in flight
//   reset: synchronous, active low; clears the pipeline valid bits and loads
//   the identity matrix with zero translation
`default_nettype none

module affine_point_transform_top #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_point_y,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_point_z,
    output logic                                    o_strobe,
    output logic signed [apt_pkg::COORD_W-1:0]      o_out_x,
    output logic signed [apt_pkg::COORD_W-1:0]      o_out_y,
    output logic signed [apt_pkg::COORD_W-1:0]      o_out_z,
    output logic                                    o_saturated,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [apt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [apt_pkg::PAIR_W-1:0]         i_cfg_data
);

    apt_pkg::t_matrix                   w_matrix;
    logic [apt_pkg::PIPE_DEPTH-1:0]     r_valid;
    logic [2:0]                         w_sat;
    logic signed [apt_pkg::COORD_W-1:0] w_coord [3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    apt_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_matrix    (w_matrix)
    );

    // lane j uses column j: entries j, 3+j, 6+j, 9+j
    for (genvar j = 0; j < 3; j++) begin : g_lane
        apt_coord_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_x     (i_point_x),
            .i_y     (i_point_y),
            .i_z     (i_point_z),
            .i_mx    (w_matrix[j]),
            .i_my    (w_matrix[3+j]),
            .i_mz    (w_matrix[6+j]),
            .i_t     (w_matrix[9+j]),
            .o_coord (w_coord[j]),
            .o_sat   (w_sat[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[apt_pkg::PIPE_DEPTH-2:0], start && !busy};
        end
    end

    assign o_strobe    = r_valid[apt_pkg::PIPE_DEPTH-1];
    assign o_out_x     = w_coord[0];
    assign o_out_y     = w_coord[1];
    assign o_out_z     = w_coord[2];
    assign o_saturated = |w_sat;

endmodule

`default_nettype wire

### src/apt_cfg_regs.sv
// matrix register file, two fixed-point entries per register, reset to identity
`default_nettype none

module apt_cfg_regs #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [apt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [apt_pkg::PAIR_W-1:0]     i_cfg_data,
    output apt_pkg::t_matrix                    o_matrix
);

    localparam logic [apt_pkg::PAIR_W-1:0] ONE_PAIR = apt_pkg::PAIR_W'(1) << FRAC_BITS;

    logic [apt_pkg::PAIR_W-1:0] r_pair [apt_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < apt_pkg::NUM_REGS; i++) begin
                // even registers hold a diagonal entry in the low half
                r_pair[i] <= (i % 2 == 0) ? ONE_PAIR : '0;
            end
        end else if (i_cfg_valid
                     && (32'(i_cfg_index) < apt_pkg::NUM_REGS)) begin
            r_pair[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int e = 0; e < apt_pkg::NUM_ENTRIES; e++) begin
            if (e % 2 == 1) begin
                o_matrix[e] = r_pair[e/2][apt_pkg::PAIR_W-1:apt_pkg::COORD_W];
            end else begin
                o_matrix[e] = r_pair[e/2][apt_pkg::COORD_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### src/apt_coord_lane.sv
// one output coordinate: multiply, two adder levels, floor shift and saturate
`default_nettype none

module apt_coord_lane #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_y,
    input  wire logic signed [apt_pkg::COORD_W-1:0] i_z,
    input  apt_pkg::t_coef                     i_mx,
    input  apt_pkg::t_coef                     i_my,
    input  apt_pkg::t_coef                     i_mz,
    input  apt_pkg::t_coef                     i_t,
    output logic signed [apt_pkg::COORD_W-1:0] o_coord,
    output logic                               o_sat
);

    localparam int P = apt_pkg::PROD_W;
    localparam int S = apt_pkg::SUM_W;
    localparam int C = apt_pkg::COORD_W;

    // stage 1: products
    logic signed [P-1:0] r_px, r_py, r_pz;
    logic signed [C-1:0] r_t;
    // stage 2: partial sums
    logic signed [P:0]   r_s01, r_s2t;
    // stage 3: full sum
    logic signed [S-1:0] r_sum;

    logic signed [P:0]   w_t_scaled;
    logic signed [S-1:0] w_shift;
    logic                w_in_range;

    assign w_t_scaled = (P+1)'(r_t) <<< FRAC_BITS;
    assign w_shift    = r_sum >>> FRAC_BITS;
    // result fits when everything above the sign bit repeats it
    assign w_in_range = (&w_shift[S-1:C-1]) || !(|w_shift[S-1:C-1]);

    always_ff @(posedge i_clk) begin
        r_px  <= P'(i_x) * P'(i_mx);
        r_py  <= P'(i_y) * P'(i_my);
        r_pz  <= P'(i_z) * P'(i_mz);
        r_t   <= i_t;

        r_s01 <= (P+1)'(r_px) + (P+1)'(r_py);
        r_s2t <= (P+1)'(r_pz) + w_t_scaled;

        r_sum <= S'(r_s01) + S'(r_s2t);

        if (w_in_range) begin
            o_coord <= w_shift[C-1:0];
            o_sat   <= 1'b0;
        end else begin
            o_coord <= r_sum[S-1] ? apt_pkg::SAT_MIN : apt_pkg::SAT_MAX;
            o_sat   <= 1'b1;
        end
    end

endmodule

`default_nettype wire
